// File: hdl/ihp_pkg.sv
// Shared types and constants for the IPv4 header parser.
package ihp_pkg;

	// Field types used on the channels and inside the parser.
	typedef logic [7:0]  octet_t;
	typedef logic [15:0] word16_t;
	typedef logic [31:0] addr_t;
	typedef logic [5:0]  hdr_pos_t;

	// Header format constants.
	localparam logic [3:0]  IPV4_VERSION      = 4'd4;
	localparam logic [3:0]  MIN_IHL           = 4'd5;
	localparam hdr_pos_t    DEFAULT_HDR_BYTES = 6'd20;
	localparam word16_t     SUM_ALL_ONES      = 16'hffff;
	localparam int unsigned DF_BIT            = 6;
	localparam int unsigned MF_BIT            = 5;

	// Byte positions of the fixed header fields.
	localparam hdr_pos_t POS_TOS       = 6'd1;
	localparam hdr_pos_t POS_TOTAL_HI  = 6'd2;
	localparam hdr_pos_t POS_TOTAL_LO  = 6'd3;
	localparam hdr_pos_t POS_IDENT_HI  = 6'd4;
	localparam hdr_pos_t POS_IDENT_LO  = 6'd5;
	localparam hdr_pos_t POS_FLAGS     = 6'd6;
	localparam hdr_pos_t POS_FRAG_LO   = 6'd7;
	localparam hdr_pos_t POS_TTL       = 6'd8;
	localparam hdr_pos_t POS_PROTO     = 6'd9;
	localparam hdr_pos_t POS_SRC_FIRST = 6'd12;
	localparam hdr_pos_t POS_SRC_LAST  = 6'd15;
	localparam hdr_pos_t POS_DST_FIRST = 6'd16;
	localparam hdr_pos_t POS_DST_LAST  = 6'd19;

endpackage

// File: hdl/ihp_if.sv
// Channel interfaces: the byte stream in and the parsed header result out.
interface ihp_byte_if;
	import ihp_pkg::*;

	logic   valid;
	logic   ready;
	octet_t data_byte;
	logic   first_byte;

	modport source (output valid, output data_byte, output first_byte, input ready);
	modport sink (input valid, input data_byte, input first_byte, output ready);
endinterface

interface ihp_result_if;
	import ihp_pkg::*;

	logic    valid;
	logic    ready;
	octet_t  type_of_service;
	word16_t payload_length;
	word16_t ident;
	logic    df_flag;
	logic    mf_flag;
	word16_t fragment_offset_bytes;
	octet_t  time_to_live;
	octet_t  protocol_number;
	addr_t   source_address;
	addr_t   destination_address;
	logic    checksum_good;
	logic    header_error;

	modport source (
		output valid, output type_of_service, output payload_length, output ident,
		output df_flag, output mf_flag, output fragment_offset_bytes,
		output time_to_live, output protocol_number, output source_address,
		output destination_address, output checksum_good, output header_error,
		input ready
	);
	modport sink (
		input valid, input type_of_service, input payload_length, input ident,
		input df_flag, input mf_flag, input fragment_offset_bytes,
		input time_to_live, input protocol_number, input source_address,
		input destination_address, input checksum_good, input header_error,
		output ready
	);
endinterface

// File: hdl/ipv4_header_parser.sv
// Top level of the IPv4 header parser with header checksum check.
//
// Usage:
//   The in channel carries one header byte per transaction, in network order;
//   first_byte marks the version/IHL byte that opens a header. A first byte in
//   the middle of a header drops the unfinished one and restarts. Bytes not
//   marked first while no header is open, and bytes after the header, are
//   dropped. The out channel gives one transaction per completed header, on its
//   last byte (IHL*4 bytes, or 20 when the version or IHL is bad).
//   checksum_enable is a one-bit register written with cfg_we/cfg_wdata; it is
//   sampled when the result is formed and must only change while idle.
// Timing:
//   A byte is registered in the input stage on acceptance and processed from
//   there into the parse state; a result is registered on its last byte. One
//   byte is accepted every cycle while no result waits on a stalled receiver;
//   the only limit is the single result register.
// Reset and stalls:
//   arst_n clears the valid flags, the parse control state and checksum_enable.
//   While the receiver holds out.ready low with a result pending, the input
//   stage stops once it is full, and in.ready falls until the result is taken.
module ipv4_header_parser (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic        cfg_wdata,
	ihp_byte_if.sink    in,
	ihp_result_if.source out
);
	import ihp_pkg::*;

	// Input stage registers.
	logic   valid_s1;
	octet_t byte_s1;
	logic   first_s1;
	logic   advance;

	// Parse state.
	logic     cksum_en_q;
	logic     parsing_q;
	hdr_pos_t pos_q;
	hdr_pos_t hdr_q;
	logic     err_q;
	word16_t  sum_q;
	octet_t   hold_q;

	// Captured header fields.
	octet_t  tos_q;
	word16_t total_q;
	word16_t ident_q;
	octet_t  flags_q;
	octet_t  frag_lo_q;
	octet_t  ttl_q;
	octet_t  proto_q;
	addr_t   src_q;
	addr_t   dst_q;

	// Next values of the parse state and fields.
	logic     active;
	logic     last;
	hdr_pos_t pos;
	hdr_pos_t hdr_len;
	logic     err;
	word16_t  sum_d;
	octet_t   hold_d;
	logic [16:0] sum_wide;
	octet_t  tos_d;
	word16_t total_d;
	word16_t ident_d;
	octet_t  flags_d;
	octet_t  frag_lo_d;
	octet_t  ttl_d;
	octet_t  proto_d;
	addr_t   src_d;
	addr_t   dst_d;
	logic    bad_first;

	// Result register.
	logic out_valid_q;

	// Handshake: the input stage moves when the result register can take a value.
	assign advance  = valid_s1 && (!out_valid_q || out.ready);
	assign in.ready = !valid_s1 || advance;

	// Input stage.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in.ready) begin
			valid_s1 <= in.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in.valid && in.ready) begin
			byte_s1  <= in.data_byte;
			first_s1 <= in.first_byte;
		end
	end

	// Configuration register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cksum_en_q <= 1'b0;
		end else if (cfg_we) begin
			cksum_en_q <= cfg_wdata;
		end
	end

	// Header start decode and position tracking.
	assign bad_first = (byte_s1[7:4] != IPV4_VERSION) || (byte_s1[3:0] < MIN_IHL);
	assign active    = first_s1 || parsing_q;
	assign pos       = first_s1 ? '0 : pos_q;
	assign err       = first_s1 ? bad_first : err_q;
	assign hdr_len   = !first_s1 ? hdr_q :
		(bad_first ? DEFAULT_HDR_BYTES : {byte_s1[3:0], 2'b00});
	assign last      = active && ((pos + 6'd1) == hdr_len);

	// Ones' complement sum with end-around carry, one 16-bit word per odd byte.
	always_comb begin
		sum_d    = first_s1 ? '0 : sum_q;
		hold_d   = hold_q;
		sum_wide = '0;
		if (pos[0]) begin
			sum_wide = {1'b0, sum_d} + {1'b0, hold_q, byte_s1};
			sum_d    = sum_wide[15:0] + {15'd0, sum_wide[16]};
		end else begin
			hold_d = byte_s1;
		end
	end

	// Field capture by byte position.
	always_comb begin
		tos_d     = tos_q;
		total_d   = total_q;
		ident_d   = ident_q;
		flags_d   = flags_q;
		frag_lo_d = frag_lo_q;
		ttl_d     = ttl_q;
		proto_d   = proto_q;
		src_d     = src_q;
		dst_d     = dst_q;
		priority if (pos == POS_TOS) begin
			tos_d = byte_s1;
		end else if (pos == POS_TOTAL_HI) begin
			total_d[15:8] = byte_s1;
		end else if (pos == POS_TOTAL_LO) begin
			total_d[7:0] = byte_s1;
		end else if (pos == POS_IDENT_HI) begin
			ident_d[15:8] = byte_s1;
		end else if (pos == POS_IDENT_LO) begin
			ident_d[7:0] = byte_s1;
		end else if (pos == POS_FLAGS) begin
			flags_d = byte_s1;
		end else if (pos == POS_FRAG_LO) begin
			frag_lo_d = byte_s1;
		end else if (pos == POS_TTL) begin
			ttl_d = byte_s1;
		end else if (pos == POS_PROTO) begin
			proto_d = byte_s1;
		end else if (pos >= POS_SRC_FIRST && pos <= POS_SRC_LAST) begin
			src_d = {src_q[23:0], byte_s1};
		end else if (pos >= POS_DST_FIRST && pos <= POS_DST_LAST) begin
			dst_d = {dst_q[23:0], byte_s1};
		end else begin
			tos_d = tos_q;
		end
	end

	// Parse control state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			parsing_q <= 1'b0;
			pos_q     <= '0;
			hdr_q     <= DEFAULT_HDR_BYTES;
			err_q     <= 1'b0;
		end else if (advance && active) begin
			parsing_q <= !last;
			pos_q     <= pos + 6'd1;
			hdr_q     <= hdr_len;
			err_q     <= err;
		end
	end

	// Sum and field registers.
	always_ff @(posedge clk) begin
		if (advance && active) begin
			sum_q     <= sum_d;
			hold_q    <= hold_d;
			tos_q     <= tos_d;
			total_q   <= total_d;
			ident_q   <= ident_d;
			flags_q   <= flags_d;
			frag_lo_q <= frag_lo_d;
			ttl_q     <= ttl_d;
			proto_q   <= proto_d;
			src_q     <= src_d;
			dst_q     <= dst_d;
		end
	end

	// Result valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= last;
		end else if (out.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Result payload, formed from the next field values on the last byte.
	always_ff @(posedge clk) begin
		if (advance && last) begin
			out.type_of_service       <= tos_d;
			out.payload_length        <= total_d - {10'd0, hdr_len};
			out.ident                 <= ident_d;
			out.df_flag               <= flags_d[DF_BIT];
			out.mf_flag               <= flags_d[MF_BIT];
			out.fragment_offset_bytes <= {flags_d[4:0], frag_lo_d, 3'b000};
			out.time_to_live          <= ttl_d;
			out.protocol_number       <= proto_d;
			out.source_address        <= src_d;
			out.destination_address   <= dst_d;
			out.checksum_good         <= !cksum_en_q || (sum_d == SUM_ALL_ONES);
			out.header_error          <= err;
		end
	end

	assign out.valid = out_valid_q;

`ifndef SYNTHESIS
	// An open header never runs past its length.
	assert property (@(posedge clk) disable iff (!arst_n)
		parsing_q |-> (pos_q < hdr_q))
		else $error("parse position beyond header length");

	// Header length is a whole number of words, at least the fixed header.
	assert property (@(posedge clk) disable iff (!arst_n)
		(hdr_q[1:0] == 2'b00) && (hdr_q >= DEFAULT_HDR_BYTES))
		else $error("header length out of range");

	// Input backpressure only comes from a full input stage behind a stalled result.
	assert property (@(posedge clk) disable iff (!arst_n)
		!in.ready |-> (valid_s1 && out_valid_q && !out.ready))
		else $error("input stalled without cause");

	// A new result follows the processing of a last header byte.
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out.valid) |-> $past(advance && last))
		else $error("result without a completed header");
`endif

endmodule

// File: test/tb_ipv4_header_parser.sv
// Self-checking testbench for the IPv4 header parser: directed headers, then random byte streams.
`timescale 1ns / 100ps

module tb_ipv4_header_parser;
	import ihp_pkg::*;

	// One parsed header as it leaves the block.
	typedef struct packed {
		octet_t  tos;
		word16_t plen;
		word16_t ident;
		logic    df;
		logic    mf;
		word16_t frag;
		octet_t  ttl;
		octet_t  proto;
		addr_t   src;
		addr_t   dst;
		logic    sum_ok;
		logic    hdr_err;
	} hdr_result_t;

	// One row of the directed table: an optional register write, then one burst of bytes.
	typedef struct packed {
		logic         cfg_wr;
		logic         cfg_val;
		logic         lead;
		logic [6:0]   len;
		logic [159:0] head;
		logic         seal;
		logic         typed;
		hdr_result_t  res;
	} dir_case_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we;
	logic cfg_wdata;

	ihp_byte_if   in_ch ();
	ihp_result_if out_ch ();

	ipv4_header_parser u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.in        (in_ch),
		.out       (out_ch)
	);

	// Predicted parser state and the register copy.
	hdr_pos_t    hp_pos = '0;
	hdr_pos_t    hp_len = DEFAULT_HDR_BYTES;
	logic        hp_busy = 1'b0;
	word16_t     hp_sum = '0;
	octet_t      hp_hold = '0;
	logic [63:0] hp_fixed = '0;
	logic [31:0] hp_mid = '0;
	logic [63:0] hp_addr = '0;
	logic        hp_err = 1'b0;
	logic        cksum_en = 1'b0;

	hdr_result_t pending_headers[$];
	dir_case_t   dir_cases[$];
	octet_t      pkt [0:63];
	int          fault_count = 0;
	int          gap_pct = 26;
	int          sink_idle_pct = 34;
	int          holds_asked = 0;

	always #4 clk = ~clk;

	// Advances the predicted parser by one accepted byte; returns 1 when a header completes.
	function automatic logic parse_byte(input octet_t b, input logic first, output hdr_result_t r);
		hdr_pos_t    pos;
		logic [16:0] acc;
		word16_t     total;
		r = '0;
		if (first) begin
			hp_fixed = '0;
			hp_mid = '0;
			hp_addr = '0;
			hp_sum = '0;
			hp_hold = '0;
			hp_pos = '0;
			hp_busy = 1'b1;
			if (b[7:4] != IPV4_VERSION || b[3:0] < MIN_IHL) begin
				hp_err = 1'b1;
				hp_len = DEFAULT_HDR_BYTES;
			end else begin
				hp_err = 1'b0;
				hp_len = {b[3:0], 2'b00};
			end
		end else if (!hp_busy) begin
			return 1'b0;
		end
		pos = hp_pos;
		if (pos < 6'd8)
			hp_fixed = {hp_fixed[55:0], b};
		else if (pos < 6'd12)
			hp_mid = {hp_mid[23:0], b};
		else if (pos < 6'd20)
			hp_addr = {hp_addr[55:0], b};
		// Even bytes are held as the high half of a word; odd bytes complete it.
		if (!pos[0]) begin
			hp_hold = b;
		end else begin
			acc = {1'b0, hp_sum} + {1'b0, hp_hold, b};
			hp_sum = acc[15:0] + {15'd0, acc[16]};
		end
		hp_pos = pos + 6'd1;
		if ({1'b0, pos} + 7'd1 < {1'b0, hp_len})
			return 1'b0;
		hp_busy = 1'b0;
		total = hp_fixed[47:32];
		r.tos = hp_fixed[55:48];
		r.plen = total - {10'd0, hp_len};
		r.ident = hp_fixed[31:16];
		r.df = hp_fixed[8 + DF_BIT];
		r.mf = hp_fixed[8 + MF_BIT];
		r.frag = {hp_fixed[12:0], 3'b000};
		r.ttl = hp_mid[31:24];
		r.proto = hp_mid[23:16];
		r.src = hp_addr[63:32];
		r.dst = hp_addr[31:0];
		r.sum_ok = cksum_en ? (hp_sum == SUM_ALL_ONES) : 1'b1;
		r.hdr_err = hp_err;
		return 1'b1;
	endfunction

	// Writes a valid header checksum into bytes 10 and 11 of the packet buffer.
	function automatic void seal_checksum();
		int          n;
		logic [16:0] acc;
		if (pkt[0][7:4] == IPV4_VERSION && pkt[0][3:0] >= MIN_IHL)
			n = 4 * pkt[0][3:0];
		else
			n = int'(DEFAULT_HDR_BYTES);
		pkt[10] = '0;
		pkt[11] = '0;
		acc = '0;
		for (int i = 0; i < n; i += 2) begin
			acc = {1'b0, acc[15:0]} + {1'b0, pkt[i], pkt[i + 1]};
			acc = {1'b0, acc[15:0]} + {16'd0, acc[16]};
		end
		{pkt[10], pkt[11]} = ~acc[15:0];
	endfunction

	function automatic string fmt_result(input hdr_result_t r);
		return $sformatf({"tos=%h len=%h id=%h df=%b mf=%b off=%h ttl=%h proto=%h ",
			"src=%h dst=%h sum_ok=%b err=%b"}, r.tos, r.plen, r.ident, r.df, r.mf, r.frag,
			r.ttl, r.proto, r.src, r.dst, r.sum_ok, r.hdr_err);
	endfunction

	task automatic add_case(input int wr, input int val, input int lead, input int len,
			input logic [159:0] head, input int seal, input int typed, input hdr_result_t res);
		dir_case_t c;
		c.cfg_wr = wr[0];
		c.cfg_val = val[0];
		c.lead = lead[0];
		c.len = len[6:0];
		c.head = head;
		c.seal = seal[0];
		c.typed = typed[0];
		c.res = res;
		dir_cases.push_back(c);
	endtask

	// Sends pkt[0..n-1], marking byte 0 as first when lead is set, with random gaps.
	task automatic send_header(input int n, input logic lead, input logic typed,
			input hdr_result_t typed_res);
		hdr_result_t r;
		for (int i = 0; i < n; i++) begin
			if (gap_pct != 0 && $urandom_range(99) < gap_pct) begin
				in_ch.valid <= 1'b0;
				repeat ($urandom_range(1, 3)) @(posedge clk);
			end
			in_ch.valid <= 1'b1;
			in_ch.data_byte <= pkt[i];
			in_ch.first_byte <= lead && i == 0;
			@(posedge clk);
			while (!in_ch.ready)
				@(posedge clk);
			if (parse_byte(pkt[i], lead && i == 0, r))
				pending_headers.push_back(typed ? typed_res : r);
		end
	endtask

	// Stops offering bytes until every predicted header has been received.
	task automatic drain();
		in_ch.valid <= 1'b0;
		@(posedge clk);
		while (pending_headers.size() != 0)
			@(posedge clk);
	endtask

	task automatic set_cksum(input logic en);
		drain();
		// Let a dropped byte still in the input stage settle before the write.
		repeat (6) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= en;
		@(posedge clk);
		cfg_we <= 1'b0;
		cksum_en = en;
	endtask

	// Result receiver: random stalls, plus long hold-offs when asked.
	initial begin
		int hold_left;
		int holds_done;
		hold_left = 0;
		holds_done = 0;
		out_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_left == 0 && holds_done != holds_asked) begin
				holds_done = holds_asked;
				hold_left = 250;
			end
			if (hold_left != 0) begin
				hold_left--;
				out_ch.ready <= 1'b0;
			end else begin
				out_ch.ready <= ($urandom_range(99) >= sink_idle_pct);
			end
		end
	end

	// Compare each received transaction with the oldest predicted header.
	always @(posedge clk) begin
		hdr_result_t got;
		hdr_result_t want;
		if (arst_n && out_ch.valid && out_ch.ready) begin
			got = '{out_ch.type_of_service, out_ch.payload_length, out_ch.ident,
				out_ch.df_flag, out_ch.mf_flag, out_ch.fragment_offset_bytes,
				out_ch.time_to_live, out_ch.protocol_number, out_ch.source_address,
				out_ch.destination_address, out_ch.checksum_good, out_ch.header_error};
			if (pending_headers.size() == 0) begin
				fault_count++;
				if (fault_count <= 10)
					$display("%0t: header result with none pending: %s", $realtime,
						fmt_result(got));
			end else begin
				want = pending_headers.pop_front();
				if (got !== want) begin
					fault_count++;
					if (fault_count <= 10) begin
						$display("%0t: header result mismatch", $realtime);
						$display("  expected %s", fmt_result(want));
						$display("  actual   %s", fmt_result(got));
					end
				end
			end
		end
	end

	// Watchdog.
	initial begin
		#2000000;
		$display("tb_ipv4_header_parser: done, errors");
		$finish;
	end

	initial begin
		int          ph;
		int          n;
		int          phase_bytes;
		int          kind;
		logic [3:0]  ihl;
		logic        lead;

		cfg_we <= 1'b0;
		cfg_wdata <= 1'b0;
		in_ch.valid <= 1'b0;
		in_ch.data_byte <= '0;
		in_ch.first_byte <= 1'b0;

		// Directed table; typed results are positional: tos, len, id, df, mf, off, ttl,
		// proto, src, dst, sum_ok, err.
		// All-zero bad header with checking off after reset.
		add_case(0, 0, 1, 20, 160'h0, 0, 1,
			'{8'h00, 16'hffec, 16'h0000, 1'b0, 1'b0, 16'h0000, 8'h00, 8'h00,
			32'h0, 32'h0, 1'b1, 1'b1});
		// All-ones bytes: bad version and every field at its maximum.
		add_case(0, 0, 1, 20, {20{8'hff}}, 0, 1,
			'{8'hff, 16'hffeb, 16'hffff, 1'b1, 1'b1, 16'hfff8, 8'hff, 8'hff,
			32'hffffffff, 32'hffffffff, 1'b1, 1'b1});
		// All-zero header with checking on: a zero sum reads as bad.
		add_case(1, 1, 1, 20, 160'h0, 0, 1,
			'{8'h00, 16'hffec, 16'h0000, 1'b0, 1'b0, 16'h0000, 8'h00, 8'h00,
			32'h0, 32'h0, 1'b0, 1'b1});
		add_case(0, 0, 1, 20, 160'h4500_0054_1c46_4000_4006_0000_c0a8_0001_c0a8_00c7, 1, 0, '0);
		// Short IHL is taken as a 20-byte header.
		add_case(0, 0, 1, 20, 160'h4412_0100_abcd_2000_8011_0000_0a00_0001_0a00_0002, 1, 0, '0);
		// Longest header, with a total length below the header length.
		add_case(0, 0, 1, 60, 160'h4fe0_0028_ffff_bfff_01fe_0000_ffff_ffff_0000_0000, 1, 0, '0);
		// A header cut short by the next first byte.
		add_case(0, 0, 1, 9, 160'h4500_1234_5678_0000_4006_0000_0101_0101_0202_0202, 0, 0, '0);
		// Options plus bytes past the end of the header.
		add_case(0, 0, 1, 27, 160'h4600_0030_0001_0000_3f11_0000_7f00_0001_7f00_0001, 1, 0, '0);
		// Unmarked bytes while no header is open.
		add_case(0, 0, 0, 3, 160'h45ff_0000_0000_0000_0000_0000_0000_0000_0000_0000, 0, 0, '0);
		add_case(0, 0, 1, 20, 160'h4500_0000_0000_0000_4006_1234_0a0a_0a0a_1414_1414, 0, 0, '0);
		add_case(0, 0, 1, 20, 160'h6500_0054_0000_4000_4006_0000_c0a8_0001_c0a8_0002, 1, 0, '0);
		// Checking off: a bad checksum still reads as good.
		add_case(1, 0, 1, 20, 160'h4500_0000_0000_0000_4006_1234_0a0a_0a0a_1414_1414, 0, 0, '0);
		add_case(0, 0, 1, 60, 160'h4fff_ffff_ffff_ffff_ffff_0000_ffff_ffff_ffff_ffff, 1, 0, '0);

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_cases[k]) begin
			if (dir_cases[k].cfg_wr)
				set_cksum(dir_cases[k].cfg_val);
			for (int i = 0; i < 64; i++)
				pkt[i] = (i < 20) ? dir_cases[k].head[159 - 8 * i -: 8] :
					octet_t'($urandom_range(255));
			if (dir_cases[k].seal)
				seal_checksum();
			send_header(int'(dir_cases[k].len), dir_cases[k].lead, dir_cases[k].typed,
				dir_cases[k].res);
		end

		// Random phases alternate the register; phase 1 runs without idling and
		// with a long receiver hold-off.
		for (ph = 0; ph < 4; ph++) begin
			set_cksum(ph[0] ? 1'b0 : 1'b1);
			gap_pct = (ph == 1) ? 0 : 26;
			sink_idle_pct = (ph == 1) ? 0 : 34;
			if (ph == 1)
				holds_asked++;
			phase_bytes = 0;
			while (phase_bytes < 270) begin
				kind = $urandom_range(99);
				for (int i = 0; i < 64; i++)
					pkt[i] = octet_t'($urandom_range(255));
				ihl = ($urandom_range(9) < 7) ? 4'd5 : 4'($urandom_range(6, 15));
				lead = 1'b1;
				if (kind < 80) begin
					// Well-formed header, mostly with a valid checksum.
					pkt[0] = {IPV4_VERSION, ihl};
					if ($urandom_range(9) < 7)
						seal_checksum();
					n = ihl * 4 + (($urandom_range(3) == 0) ? $urandom_range(1, 4) : 0);
				end else if (kind < 88) begin
					// Bad version or short IHL.
					if (pkt[0][7:4] == IPV4_VERSION && pkt[0][3:0] >= MIN_IHL)
						pkt[0][3:0] = 4'($urandom_range(4));
					if ($urandom_range(1) == 1)
						seal_checksum();
					n = 20 + (($urandom_range(3) == 0) ? $urandom_range(1, 4) : 0);
				end else if (kind < 95) begin
					// Truncated header; the next first byte restarts parsing.
					pkt[0] = {IPV4_VERSION, ihl};
					n = $urandom_range(1, ihl * 4 - 1);
				end else begin
					lead = 1'b0;
					n = $urandom_range(1, 4);
				end
				send_header(n, lead, 1'b0, '0);
				phase_bytes += n;
				if (ph != 1 && $urandom_range(99) < 3)
					drain();
			end
		end

		drain();
		repeat (10) @(posedge clk);
		if (fault_count == 0 && pending_headers.size() == 0)
			$display("tb_ipv4_header_parser: done, clean");
		else
			$display("tb_ipv4_header_parser: done, errors");
		$finish;
	end

endmodule

// File: filelist.f
hdl/ihp_pkg.sv
hdl/ihp_if.sv
hdl/ipv4_header_parser.sv
test/tb_ipv4_header_parser.sv
